// ----- design/assert_macros.svh -----
// Assertion helpers; clk and rst are taken from the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define XSED_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define XSED_ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`else

`define XSED_ASSERT(lbl, cond, msg)

`define XSED_ASSERT_IMPLY(lbl, pre, post, msg)

`endif

`endif

// ----- design/xsed_pkg.sv -----
package xsed_pkg;

  localparam int TABLE_DEPTH     = 1024;
  localparam int IDX_W           = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int MAX_FIELD_BYTES = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic REQ_HEADER = 1'b0;
  localparam logic REQ_BYTE   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TYPE_WIDTH    = 2'd0,
    CFG_SECOND_WIDTH  = 2'd1,
    CFG_THIRD_WIDTH   = 2'd2,
    CFG_TABLE_ENTRIES = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_RECORDED   = 3'd0,
    ST_SKIPPED    = 3'd1,
    ST_BAD_TYPE   = 3'd2,
    ST_EARLY_END  = 3'd3,
    ST_ZERO_WIDTH = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_FREE       = 2'd0,
    KIND_IN_USE     = 2'd1,
    KIND_COMPRESSED = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_STATUS = 2'd1,
    EV_ENTRY  = 2'd2
  } ev_action_t;

  // One classified beat handed from front to back
  typedef struct packed {
    logic             clr_squash;
    ev_action_t       action;
    status_t          status;
    logic [31:0]      obj;
    logic             in_table;
    logic [IDX_W-1:0] idx;
    logic             kind_bad;
    logic [1:0]       kind;
    logic [63:0]      v1;
    logic [31:0]      v2;
  } xsed_event_t;

  typedef struct packed {
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  function automatic logic [3:0] clampw(input logic [3:0] w);
    return (w > 4'(MAX_FIELD_BYTES)) ? 4'(MAX_FIELD_BYTES) : w;
  endfunction

endpackage

// ----- design/xsed_if.sv -----
interface xsed_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] first_object;
  logic [31:0] entry_count;
  logic [7:0]  stream_byte;
  logic        stream_end;

  modport source (
    output valid, req_type, first_object, entry_count, stream_byte, stream_end,
    input  ready
  );
  modport sink (
    input  valid, req_type, first_object, entry_count, stream_byte, stream_end,
    output ready
  );
endinterface

interface xsed_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] object_number;
  logic [2:0]  status;
  logic [1:0]  entry_kind;
  logic [63:0] first_value;
  logic [31:0] second_value;

  modport source (
    output valid, object_number, status, entry_kind, first_value, second_value,
    input  ready
  );
  modport sink (
    input  valid, object_number, status, entry_kind, first_value, second_value,
    output ready
  );
endinterface

// ----- design/xsed_front.sv -----
module xsed_front (
  input  logic                            clk,
  input  logic                            rst,
  xsed_in_if.sink                         items,
  input  logic                            cfg_write,
  input  logic [xsed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [xsed_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            clearing,
  input  xsed_pkg::q_stat_t               qstat,
  output logic                            push,
  output xsed_pkg::xsed_event_t           ev
);

  logic [3:0]  type_width, second_width, third_width;
  logic [10:0] table_entries;

  logic [31:0] next_object, next_object_next;
  logic [31:0] entries_left, entries_left_next;
  logic [4:0]  byte_position, byte_position_next;
  logic [63:0] type_accum, type_accum_next;
  logic [63:0] second_accum, second_accum_next;
  logic [63:0] third_accum, third_accum_next;
  logic        halted, halted_next;

  logic [3:0]  tw, sw, gw;
  logic [4:0]  total, tw_sw;
  logic [5:0]  pos_inc;
  logic [63:0] kind64;
  logic        accept;

  assign tw      = xsed_pkg::clampw(type_width);
  assign sw      = xsed_pkg::clampw(second_width);
  assign gw      = xsed_pkg::clampw(third_width);
  assign tw_sw   = 5'(tw) + 5'(sw);
  assign total   = tw_sw + 5'(gw);
  assign pos_inc = 6'(byte_position) + 6'd1;

  assign items.ready = !clearing && !qstat.full;
  assign accept      = items.valid && items.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      type_width    <= 4'd1;
      second_width  <= 4'd4;
      third_width   <= 4'd2;
      table_entries <= 11'd1024;
    end else if (cfg_write) begin
      unique case (xsed_pkg::cfg_index_t'(cfg_index))
        xsed_pkg::CFG_TYPE_WIDTH:    type_width    <= cfg_data[3:0];
        xsed_pkg::CFG_SECOND_WIDTH:  second_width  <= cfg_data[3:0];
        xsed_pkg::CFG_THIRD_WIDTH:   third_width   <= cfg_data[3:0];
        xsed_pkg::CFG_TABLE_ENTRIES: table_entries <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    next_object_next   = next_object;
    entries_left_next  = entries_left;
    byte_position_next = byte_position;
    type_accum_next    = type_accum;
    second_accum_next  = second_accum;
    third_accum_next   = third_accum;
    halted_next        = halted;
    kind64             = 64'd0;
    push               = 1'b0;
    ev                 = '0;
    ev.action          = xsed_pkg::EV_NONE;
    ev.status          = xsed_pkg::ST_RECORDED;
    ev.obj             = next_object;

    if (accept) begin
      if (items.req_type == xsed_pkg::REQ_HEADER) begin
        next_object_next   = items.first_object;
        entries_left_next  = items.entry_count;
        halted_next        = 1'b0;
        byte_position_next = 5'd0;
        type_accum_next    = 64'd0;
        second_accum_next  = 64'd0;
        third_accum_next   = 64'd0;
        // every header goes through the queue so the back side drops its squash
        push          = 1'b1;
        ev.clr_squash = 1'b1;
        ev.obj        = items.first_object;
        if (items.entry_count != 32'd0 && total == 5'd0) begin
          halted_next = 1'b1;
          ev.action   = xsed_pkg::EV_STATUS;
          ev.status   = xsed_pkg::ST_ZERO_WIDTH;
        end
      end else if (!halted && entries_left != 32'd0) begin
        if (total == 5'd0) begin
          halted_next = 1'b1;
          push        = 1'b1;
          ev.action   = xsed_pkg::EV_STATUS;
          ev.status   = xsed_pkg::ST_ZERO_WIDTH;
        end else begin
          if (byte_position < 5'(tw))
            type_accum_next = {type_accum[55:0], items.stream_byte};
          else if (byte_position < tw_sw)
            second_accum_next = {second_accum[55:0], items.stream_byte};
          else
            third_accum_next = {third_accum[55:0], items.stream_byte};

          if (pos_inc < 6'(total)) begin
            byte_position_next = pos_inc[4:0];
            if (items.stream_end) begin
              halted_next        = 1'b1;
              push               = 1'b1;
              ev.action          = xsed_pkg::EV_STATUS;
              ev.status          = xsed_pkg::ST_EARLY_END;
              byte_position_next = 5'd0;
              type_accum_next    = 64'd0;
              second_accum_next  = 64'd0;
              third_accum_next   = 64'd0;
            end
          end else begin
            kind64      = (tw == 4'd0) ? 64'd1 : type_accum_next;
            push        = 1'b1;
            ev.action   = xsed_pkg::EV_ENTRY;
            ev.in_table = (next_object < 32'(table_entries)) &&
                          (next_object < 32'(xsed_pkg::TABLE_DEPTH));
            ev.idx      = next_object[xsed_pkg::IDX_W-1:0];
            ev.kind_bad = kind64 > 64'd2;
            ev.kind     = kind64[1:0];
            ev.v1       = second_accum_next;
            ev.v2       = third_accum_next[31:0];
            next_object_next   = next_object + 32'd1;
            entries_left_next  = entries_left - 32'd1;
            byte_position_next = 5'd0;
            type_accum_next    = 64'd0;
            second_accum_next  = 64'd0;
            third_accum_next   = 64'd0;
            if (items.stream_end)
              halted_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_object   <= 32'd0;
      entries_left  <= 32'd0;
      byte_position <= 5'd0;
      type_accum    <= 64'd0;
      second_accum  <= 64'd0;
      third_accum   <= 64'd0;
      halted        <= 1'b0;
    end else begin
      next_object   <= next_object_next;
      entries_left  <= entries_left_next;
      byte_position <= byte_position_next;
      type_accum    <= type_accum_next;
      second_accum  <= second_accum_next;
      third_accum   <= third_accum_next;
      halted        <= halted_next;
    end
  end

endmodule

// ----- design/xsed_queue.sv -----
module xsed_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  xsed_pkg::xsed_event_t push_ev,
  input  logic                  pop,
  output logic                  head_valid,
  output xsed_pkg::xsed_event_t head_ev,
  output xsed_pkg::q_stat_t     qstat
);

  xsed_pkg::xsed_event_t          slots [xsed_pkg::QDEPTH];
  logic [xsed_pkg::QPTR_W-1:0]    wptr, rptr;
  logic [xsed_pkg::QCNT_W-1:0]    count;

  assign head_valid  = count != '0;
  assign head_ev     = slots[rptr];
  assign qstat.full  = count == xsed_pkg::QCNT_W'(xsed_pkg::QDEPTH);
  assign qstat.count = count;

  always_ff @(posedge clk) begin
    if (push)
      slots[wptr] <= push_ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push)
        wptr <= wptr + 1'b1;
      if (pop)
        rptr <= rptr + 1'b1;
      if (push && !pop)
        count <= count + 1'b1;
      else if (pop && !push)
        count <= count - 1'b1;
    end
  end

endmodule

// ----- design/xsed_back.sv -----
module xsed_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  xsed_pkg::xsed_event_t head_ev,
  output logic                  pop,
  output logic                  clearing,
  xsed_out_if.source            results
);

  logic marks_mem [xsed_pkg::TABLE_DEPTH];
  logic [xsed_pkg::IDX_W-1:0] clr_addr;

  logic                  b_valid;
  xsed_pkg::xsed_event_t b_ev;
  logic                  rdata_q, fwd_q;
  logic                  squash, squash_next;

  logic                  o_valid;
  logic [31:0]           o_obj;
  xsed_pkg::status_t     o_status;
  logic [1:0]            o_kind;
  logic [63:0]           o_v1;
  logic [31:0]           o_v2;

  logic              o_free, b_fire, b_load, marked, emit, wr_mark;
  xsed_pkg::status_t st;
  logic [1:0]        kind;
  logic [63:0]       v1;
  logic [31:0]       v2;

  assign o_free = !o_valid || results.ready;
  assign b_fire = b_valid && o_free;
  assign b_load = head_valid && (!b_valid || b_fire) && !clearing;
  assign pop    = b_load;
  // mark written by the beat leaving stage B is not yet in the read data
  assign marked = rdata_q | fwd_q;

  always_comb begin
    emit        = 1'b0;
    wr_mark     = 1'b0;
    st          = xsed_pkg::ST_RECORDED;
    kind        = 2'd0;
    v1          = 64'd0;
    v2          = 32'd0;
    squash_next = b_ev.clr_squash ? 1'b0 : squash;
    unique case (b_ev.action)
      xsed_pkg::EV_NONE: ;
      xsed_pkg::EV_STATUS: begin
        emit = 1'b1;
        st   = b_ev.status;
      end
      xsed_pkg::EV_ENTRY: begin
        emit = 1'b1;
        if (b_ev.in_table && !marked) begin
          if (b_ev.kind_bad) begin
            st          = xsed_pkg::ST_BAD_TYPE;
            squash_next = 1'b1;
          end else begin
            st      = xsed_pkg::ST_RECORDED;
            wr_mark = 1'b1;
            kind    = b_ev.kind;
            v1      = b_ev.v1;
            v2      = b_ev.v2;
          end
        end else begin
          st = xsed_pkg::ST_SKIPPED;
        end
      end
      default: ;
    endcase
    // halted by a bad type: everything up to the next header is dropped
    if (squash && !b_ev.clr_squash) begin
      emit        = 1'b0;
      wr_mark     = 1'b0;
      squash_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing)
      marks_mem[clr_addr] <= 1'b0;
    else if (b_fire && wr_mark)
      marks_mem[b_ev.idx] <= 1'b1;
    if (b_load) begin
      rdata_q <= marks_mem[head_ev.idx];
      fwd_q   <= b_fire && wr_mark && (b_ev.idx == head_ev.idx);
      b_ev    <= head_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == xsed_pkg::IDX_W'(xsed_pkg::TABLE_DEPTH - 1))
        clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      squash  <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (b_load)
        b_valid <= 1'b1;
      else if (b_fire)
        b_valid <= 1'b0;
      if (b_fire)
        squash <= squash_next;
      if (b_fire && emit)
        o_valid <= 1'b1;
      else if (results.ready)
        o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && emit) begin
      o_obj    <= b_ev.obj;
      o_status <= st;
      o_kind   <= kind;
      o_v1     <= v1;
      o_v2     <= v2;
    end
  end

  assign results.valid         = o_valid;
  assign results.object_number = o_obj;
  assign results.status        = o_status;
  assign results.entry_kind    = o_kind;
  assign results.first_value   = o_v1;
  assign results.second_value  = o_v2;

endmodule

// ----- design/xref_stream_entry_decoder_top.sv -----
// Cross-reference stream entry decoder.
// items: one beat per header (req_type 0: first_object, entry_count) or per
//   stream byte (req_type 1: stream_byte, stream_end on the last byte).
// results: one beat per finished entry or error: object_number, status,
//   entry_kind, first_value, second_value.
// cfg_write/cfg_index/cfg_data: register writes, taken any cycle, used from the
//   next accepted beat on.
// Throughput: one item per cycle while items.ready is high. The front classifies
//   a beat in the cycle it is accepted and queues it; the back loads the queue
//   head into stage B while reading the mark memory, then decides and fills the
//   output register that drives results.valid.
// A 4-deep queue parts front and back; the output register parts the back
//   from the receiver. While results stalls, items keep flowing until the
//   queue fills, then items.ready drops.
// Reset: a clearing pass zeroes the 1024-entry mark memory, one entry a
//   cycle; items.ready stays low until the pass is done.
`include "assert_macros.svh"

module xref_stream_entry_decoder_top (
  input  logic                            clk,
  input  logic                            rst,
  xsed_in_if.sink                         items,
  xsed_out_if.source                      results,
  input  logic                            cfg_write,
  input  logic [xsed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [xsed_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                  clearing;
  logic                  push, pop, head_valid;
  xsed_pkg::xsed_event_t push_ev, head_ev;
  xsed_pkg::q_stat_t     qstat;

  xsed_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .clearing  (clearing),
    .qstat     (qstat),
    .push      (push),
    .ev        (push_ev)
  );

  xsed_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ev    (push_ev),
    .pop        (pop),
    .head_valid (head_valid),
    .head_ev    (head_ev),
    .qstat      (qstat)
  );

  xsed_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_ev    (head_ev),
    .pop        (pop),
    .clearing   (clearing),
    .results    (results)
  );

  `XSED_ASSERT(a_no_accept_clearing, !(clearing && items.ready), "beat accepted during clear")
  `XSED_ASSERT_IMPLY(a_header_pushes, items.valid && items.ready && items.req_type == xsed_pkg::REQ_HEADER, push, "header not queued")
  `XSED_ASSERT(a_queue_bound, qstat.count <= xsed_pkg::QCNT_W'(xsed_pkg::QDEPTH), "queue overflow")
  `XSED_ASSERT_IMPLY(a_no_result_clearing, clearing, !results.valid, "result during clear")

endmodule

// ----- tb/xref_stream_entry_decoder_top_tb.sv -----
module xref_stream_entry_decoder_top_tb;
  import xsed_pkg::*;

  localparam int N_PHASES        = 9;
  localparam int BEATS_PER_PHASE = 210;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_CYCLES     = 300;
  localparam int QUIET_LIMIT     = 4000;
  localparam int SCRIPT_ROWS     = 32;
  localparam int MAX_PRINTED     = 100;

  typedef struct packed {
    logic [31:0] obj;
    status_t     status;
    kind_t       kind;
    logic [63:0] first_value;
    logic [31:0] second_value;
  } entry_t;

  localparam entry_t NO_ENTRY = '0;

  typedef enum logic [1:0] {
    ROW_CFG  = 2'd0,
    ROW_HDR  = 2'd1,
    ROW_BYTE = 2'd2
  } row_op_t;

  // a/b: register index and value, first object and count, or byte and end flag
  typedef struct packed {
    row_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
    logic        typed;
    entry_t      want;
  } row_t;

  typedef struct packed {
    logic [3:0]  tw, sw, gw;
    logic [10:0] tbl;
    logic [6:0]  tx_pct, rx_pct;
    logic        hold;
  } phase_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  xsed_in_if  items_if ();
  xsed_out_if results_if ();

  xref_stream_entry_decoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .items     (items_if),
    .results   (results_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // decoder state as predicted
  logic [3:0]  cfg_tw;
  logic [3:0]  cfg_sw;
  logic [3:0]  cfg_gw;
  logic [10:0] cfg_tbl;
  bit          slot_used [TABLE_DEPTH];
  logic [31:0] cur_obj;
  logic [31:0] ents_left;
  logic [4:0]  byte_pos;
  logic [63:0] type_acc;
  logic [63:0] off_acc;
  logic [63:0] gen_acc;
  logic        stopped;

  entry_t entries_due [$];

  int unsigned n_beats;
  int unsigned n_results;
  int unsigned n_errors;
  int unsigned quiet_cycles;
  int unsigned status_hits [5];
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  bit          hold_results;

  row_t   script [SCRIPT_ROWS];
  phase_t plan [N_PHASES];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned field_bytes(logic [3:0] w);
    return (w > MAX_FIELD_BYTES) ? MAX_FIELD_BYTES : int'(w);
  endfunction

  function automatic entry_t entry_of(logic [31:0] obj, status_t st, kind_t k,
                                      logic [63:0] v1, logic [31:0] v2);
    entry_t e;
    e.obj          = obj;
    e.status       = st;
    e.kind         = k;
    e.first_value  = v1;
    e.second_value = v2;
    return e;
  endfunction

  function automatic void clear_fields();
    byte_pos = '0;
    type_acc = '0;
    off_acc  = '0;
    gen_acc  = '0;
  endfunction

  function automatic bit decode_beat(input logic rq, input logic [31:0] first,
                                     input logic [31:0] count, input logic [7:0] b,
                                     input logic fin, output entry_t res);
    int unsigned tw, sw, gw, total, pos, limit;
    logic [31:0] obj;
    logic [63:0] kind_val, v1, v2;
    tw    = field_bytes(cfg_tw);
    sw    = field_bytes(cfg_sw);
    gw    = field_bytes(cfg_gw);
    total = tw + sw + gw;
    res   = NO_ENTRY;
    if (rq == REQ_HEADER) begin
      cur_obj   = first;
      ents_left = count;
      stopped   = 1'b0;
      clear_fields();
      if (ents_left != 0 && total == 0) begin
        stopped    = 1'b1;
        res.obj    = cur_obj;
        res.status = ST_ZERO_WIDTH;
        return 1'b1;
      end
      return 1'b0;
    end
    if (stopped || ents_left == 0) return 1'b0;
    if (total == 0) begin
      stopped    = 1'b1;
      res.obj    = cur_obj;
      res.status = ST_ZERO_WIDTH;
      return 1'b1;
    end
    pos = byte_pos;
    if (pos < tw) type_acc = {type_acc[55:0], b};
    else if (pos < tw + sw) off_acc = {off_acc[55:0], b};
    else gen_acc = {gen_acc[55:0], b};
    if (pos + 1 < total) begin
      byte_pos = 5'(pos + 1);
      if (fin) begin
        stopped    = 1'b1;
        res.obj    = cur_obj;
        res.status = ST_EARLY_END;
        clear_fields();
        return 1'b1;
      end
      return 1'b0;
    end
    // entry complete (also when a width shrank below the current position)
    obj      = cur_obj;
    limit    = (cfg_tbl < TABLE_DEPTH) ? int'(cfg_tbl) : TABLE_DEPTH;
    kind_val = (tw == 0) ? 64'd1 : type_acc;
    v1       = off_acc;
    v2       = gen_acc;
    clear_fields();
    cur_obj   = obj + 32'd1;
    ents_left = ents_left - 32'd1;
    if (fin) stopped = 1'b1;
    res.obj = obj;
    if (obj < limit && !slot_used[obj[IDX_W-1:0]]) begin
      if (kind_val > 64'd2) begin
        stopped    = 1'b1;
        res.status = ST_BAD_TYPE;
        return 1'b1;
      end
      slot_used[obj[IDX_W-1:0]] = 1'b1;
      res.status       = ST_RECORDED;
      res.kind         = kind_t'(kind_val[1:0]);
      res.first_value  = v1;
      res.second_value = v2[31:0];
      return 1'b1;
    end
    res.status = ST_SKIPPED;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (n_errors < MAX_PRINTED)
      $display("mismatch on %s at result %0d: got %0h, expected %0h",
               what, n_results, got, want);
    n_errors++;
  endtask

  task automatic send_beat(logic rq, logic [31:0] first, logic [31:0] count,
                           logic [7:0] b, logic fin, bit typed, entry_t typed_res);
    entry_t res;
    bit     got;
    bit     ignored;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      items_if.valid <= 1'b0;
      @(posedge clk);
    end
    items_if.valid        <= 1'b1;
    items_if.req_type     <= rq;
    items_if.first_object <= first;
    items_if.entry_count  <= count;
    items_if.stream_byte  <= b;
    items_if.stream_end   <= fin;
    do @(posedge clk); while (items_if.ready !== 1'b1);
    ignored = (rq == REQ_BYTE) && (stopped || ents_left == 0);
    got = decode_beat(rq, first, count, b, fin, res);
    if (typed) entries_due.insert(entries_due.size(), typed_res);
    else if (got) entries_due.insert(entries_due.size(), res);
    if (!ignored) n_beats++;
  endtask

  task automatic send_hdr(logic [31:0] first, logic [31:0] count);
    send_beat(REQ_HEADER, first, count, 8'($urandom_range(255)), 1'($urandom_range(1)),
              1'b0, NO_ENTRY);
  endtask

  task automatic send_byte(logic [7:0] b, logic fin);
    send_beat(REQ_BYTE, $urandom, $urandom, b, fin, 1'b0, NO_ENTRY);
  endtask

  task automatic wait_drained();
    items_if.valid <= 1'b0;
    while (entries_due.size() != 0) @(posedge clk);
    // ignored beats may still be in flight behind the last result
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t sel, logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    case (sel)
      CFG_TYPE_WIDTH:   cfg_tw  = val[3:0];
      CFG_SECOND_WIDTH: cfg_sw  = val[3:0];
      CFG_THIRD_WIDTH:  cfg_gw  = val[3:0];
      default:          cfg_tbl = val;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // header plus whole entries with random content; mostly legal types
  task automatic random_subsection();
    int unsigned tw, sw, gw, total, n_ent, n_bytes, stop_at, p, sel;
    logic [31:0] first;
    logic [7:0]  b;
    bit          clean, close_stream, fin;
    tw    = field_bytes(cfg_tw);
    sw    = field_bytes(cfg_sw);
    gw    = field_bytes(cfg_gw);
    total = tw + sw + gw;
    clean = 1'b1;
    sel   = $urandom_range(99);
    if (sel < 70) first = $urandom_range(1100);
    else if (sel < 85) first = $urandom;
    else first = 32'hFFFF_FFFF - $urandom_range(3);
    n_ent        = $urandom_range(1, 6);
    n_bytes      = n_ent * total;
    stop_at      = n_bytes;
    close_stream = ($urandom_range(99) < 30);
    if (n_bytes != 0 && $urandom_range(99) < 6) stop_at = $urandom_range(n_bytes - 1);
    send_hdr(first, n_ent);
    for (int unsigned i = 0; i < n_bytes; i++) begin
      p = i % total;
      if (p == 0) clean = ($urandom_range(99) < 88);
      if (p < tw && clean) b = (p == tw - 1) ? 8'($urandom_range(2)) : 8'h00;
      else b = 8'($urandom_range(255));
      fin = (i == stop_at) || (close_stream && i == n_bytes - 1);
      send_byte(b, fin);
      if (i == stop_at) break;
    end
  endtask

  task automatic random_noise();
    int unsigned n;
    case ($urandom_range(3))
      0: send_hdr($urandom, $urandom);
      1: send_hdr($urandom_range(1100), 32'd0);
      2: begin
        n = $urandom_range(1, 5);
        repeat (n) send_byte(8'($urandom_range(255)), $urandom_range(99) < 20);
      end
      default: send_byte(8'($urandom_range(255)), 1'b1);
    endcase
  endtask

  initial begin : result_sink
    results_if.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (hold_results) begin
        results_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        results_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    entry_t want;
    if (results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
      n_results++;
      if (results_if.status < 5) status_hits[results_if.status]++;
      if (entries_due.size() == 0) begin
        report_mismatch("unexpected beat, object_number", results_if.object_number, '0);
      end else begin
        want = entries_due.pop_front();
        if (results_if.object_number !== want.obj)
          report_mismatch("object_number", results_if.object_number, want.obj);
        if (results_if.status !== want.status)
          report_mismatch("status", results_if.status, want.status);
        if (results_if.entry_kind !== want.kind)
          report_mismatch("entry_kind", results_if.entry_kind, want.kind);
        if (results_if.first_value !== want.first_value)
          report_mismatch("first_value", results_if.first_value, want.first_value);
        if (results_if.second_value !== want.second_value)
          report_mismatch("second_value", results_if.second_value, want.second_value);
      end
    end
  end

  always @(posedge clk) begin
    if ((items_if.valid === 1'b1 && items_if.ready === 1'b1) ||
        (results_if.valid === 1'b1 && results_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles, %0d results outstanding",
               quiet_cycles, entries_due.size());
      $display("FAIL xref_stream_entry_decoder_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned goal;
    rst                   = 1'b1;
    cfg_write             = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    items_if.valid        = 1'b0;
    items_if.req_type     = REQ_HEADER;
    items_if.first_object = '0;
    items_if.entry_count  = '0;
    items_if.stream_byte  = '0;
    items_if.stream_end   = 1'b0;
    n_beats               = 0;
    n_results             = 0;
    n_errors              = 0;
    quiet_cycles          = 0;
    tx_idle_pct           = 0;
    rx_stall_pct          = 0;
    hold_results          = 1'b0;
    foreach (status_hits[s]) status_hits[s] = 0;
    foreach (slot_used[s]) slot_used[s] = 1'b0;
    cfg_tw    = 4'd1;
    cfg_sw    = 4'd4;
    cfg_gw    = 4'd2;
    cfg_tbl   = 11'd1024;
    cur_obj   = '0;
    ents_left = '0;
    stopped   = 1'b0;
    clear_fields();

    script = '{
      // reset widths 1/4/2: all-ones offset and generation
      '{ROW_HDR,  32'd0,  32'd2, 1'b0, NO_ENTRY},
      '{ROW_BYTE, 32'h02, 32'd0, 1'b0, NO_ENTRY},
      '{ROW_BYTE, 32'hFF, 32'd0, 1'b0, NO_ENTRY},
      '{ROW_BYTE, 32'hFF, 32'd0, 1'b0, NO_ENTRY},
      '{ROW_BYTE, 32'hFF, 32'd0, 1'b0, NO_ENTRY},
      '{ROW_BYTE, 32'hFF, 32'd0, 1'b0, NO_ENTRY},
      '{ROW_BYTE, 32'hFF, 32'd0, 1'b0, NO_ENTRY},
      '{ROW_BYTE, 32'hFF, 32'd0, 1'b1,
        entry_of(32'd0, ST_RECORDED, KIND_COMPRESSED, 64'hFFFF_FFFF, 32'hFFFF)},
      // narrow the widths between entries of one subsection
      '{ROW_CFG,  32'(CFG_TYPE_WIDTH),   32'd1, 1'b0, NO_ENTRY},
      '{ROW_CFG,  32'(CFG_SECOND_WIDTH), 32'd1, 1'b0, NO_ENTRY},
      '{ROW_CFG,  32'(CFG_THIRD_WIDTH),  32'd1, 1'b0, NO_ENTRY},
      '{ROW_BYTE, 32'h00, 32'd0, 1'b0, NO_ENTRY},
      '{ROW_BYTE, 32'h00, 32'd0, 1'b0, NO_ENTRY},
      '{ROW_BYTE, 32'h00, 32'd0, 1'b1, entry_of(32'd1, ST_RECORDED, KIND_FREE, '0, '0)},
      // object 0 already marked
      '{ROW_HDR,  32'd0,  32'd1, 1'b0, NO_ENTRY},
      '{ROW_BYTE, 32'h01, 32'd0, 1'b0, NO_ENTRY},
      '{ROW_BYTE, 32'hAA, 32'd0, 1'b0, NO_ENTRY},
      '{ROW_BYTE, 32'hBB, 32'd0, 1'b1, entry_of(32'd0, ST_SKIPPED, KIND_FREE, '0, '0)},
      // type 3, then a dropped byte while halted
      '{ROW_HDR,  32'd5,  32'd3, 1'b0, NO_ENTRY},
      '{ROW_BYTE, 32'h03, 32'd0, 1'b0, NO_ENTRY},
      '{ROW_BYTE, 32'h11, 32'd0, 1'b0, NO_ENTRY},
      '{ROW_BYTE, 32'h22, 32'd0, 1'b1, entry_of(32'd5, ST_BAD_TYPE, KIND_FREE, '0, '0)},
      '{ROW_BYTE, 32'h7F, 32'd0, 1'b0, NO_ENTRY},
      // stream ends inside an entry
      '{ROW_HDR,  32'd6,  32'd2, 1'b0, NO_ENTRY},
      '{ROW_BYTE, 32'h01, 32'd0, 1'b0, NO_ENTRY},
      '{ROW_BYTE, 32'h22, 32'd1, 1'b1, entry_of(32'd6, ST_EARLY_END, KIND_FREE, '0, '0)},
      // all widths zero
      '{ROW_CFG,  32'(CFG_TYPE_WIDTH),   32'd0, 1'b0, NO_ENTRY},
      '{ROW_CFG,  32'(CFG_SECOND_WIDTH), 32'd0, 1'b0, NO_ENTRY},
      '{ROW_CFG,  32'(CFG_THIRD_WIDTH),  32'd0, 1'b0, NO_ENTRY},
      '{ROW_HDR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
        entry_of(32'hFFFF_FFFF, ST_ZERO_WIDTH, KIND_FREE, '0, '0)},
      '{ROW_HDR,  32'd0,  32'd0, 1'b0, NO_ENTRY},
      '{ROW_BYTE, 32'h80, 32'd1, 1'b0, NO_ENTRY}
    };

    // tw sw gw table, sender idle %, receiver stall %, long hold
    plan = '{
      '{4'd1,  4'd4, 4'd2,  11'd1024, 7'd0,  7'd0,  1'b0},
      '{4'd0,  4'd2, 4'd1,  11'd512,  7'd74, 7'd0,  1'b0},
      '{4'd8,  4'd8, 4'd8,  11'd2047, 7'd0,  7'd74, 1'b0},
      '{4'd15, 4'd9, 4'd12, 11'd1000, 7'd14, 7'd14, 1'b0},
      '{4'd1,  4'd0, 4'd0,  11'd0,    7'd0,  7'd0,  1'b1},
      '{4'd2,  4'd1, 4'd3,  11'd1,    7'd74, 7'd0,  1'b0},
      '{4'd0,  4'd0, 4'd0,  11'd700,  7'd0,  7'd74, 1'b0},
      '{4'd1,  4'd3, 4'd1,  11'd1024, 7'd14, 7'd14, 1'b0},
      '{4'd1,  4'd2, 4'd2,  11'd1023, 7'd0,  7'd0,  1'b0}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[r]) begin
      case (script[r].op)
        ROW_CFG: begin
          wait_drained();
          write_reg(cfg_index_t'(script[r].a[CFG_IDX_W-1:0]), script[r].b[CFG_DATA_W-1:0]);
        end
        ROW_HDR:
          send_beat(REQ_HEADER, script[r].a, script[r].b, 8'h00, 1'b0,
                    script[r].typed, script[r].want);
        default:
          send_beat(REQ_BYTE, 32'd0, 32'd0, script[r].a[7:0], script[r].b[0],
                    script[r].typed, script[r].want);
      endcase
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      write_reg(CFG_TYPE_WIDTH, CFG_DATA_W'(plan[ph].tw));
      write_reg(CFG_SECOND_WIDTH, CFG_DATA_W'(plan[ph].sw));
      write_reg(CFG_THIRD_WIDTH, CFG_DATA_W'(plan[ph].gw));
      write_reg(CFG_TABLE_ENTRIES, plan[ph].tbl);
      tx_idle_pct  = plan[ph].tx_pct;
      rx_stall_pct = plan[ph].rx_pct;
      if (plan[ph].hold) hold_results = 1'b1;
      goal = n_beats + BEATS_PER_PHASE;
      while (n_beats < goal) begin
        if ($urandom_range(99) < 80) random_subsection();
        else random_noise();
      end
    end
    wait_drained();

    $display("run: %0d live beats, directed table then %0d random phases over widths 0..15,",
             n_beats, N_PHASES);
    $display("  tables 0..2047, idle mixes and a long hold; %0d results (%0d rec, %0d skip, %0d bad, %0d early, %0d zero)",
             n_results, status_hits[ST_RECORDED], status_hits[ST_SKIPPED],
             status_hits[ST_BAD_TYPE], status_hits[ST_EARLY_END], status_hits[ST_ZERO_WIDTH]);
    if (n_errors == 0) begin
      $display("PASS xref_stream_entry_decoder_top");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("FAIL xref_stream_entry_decoder_top");
    end
    $finish;
  end

endmodule
